>>> design/sle_pkg.sv
// Package for the string literal unescaper: item types, the decoded group
// carried between the front and back parts, and character constants.
// No dependencies.
`default_nettype none

package sle_pkg;

  // Input and result items.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } sle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
  } sle_out_t;

  // One input item decodes into at most this many result bytes.
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // Depth of the group queue between the decoder and the serializer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // A decoded group: the bytes one input item produced.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     fin;
  } sle_group_t;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharLowerX    = 8'h78;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharNul       = 8'h00;

  // Returns {valid, value} for a hex digit in either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/string_literal_unescaper.sv
// Top level of the string literal unescaper: decoder, group queue and
// serializer. Depends on sle_pkg, sle_front, sle_queue and sle_back.
//
// Usage: raw body bytes of a quoted literal (quotes removed) enter on the
// input queue port: an item is taken at a clock edge with push_i high and
// full_o low, and is_final marks the last body byte. Decoded bytes leave on
// the result queue port: the oldest result sits on out_o while empty_o is
// low and is taken at an edge with pop_i high.
// A byte that yields results has its decoded group registered in the group
// queue before its first result shows on out_o. A backslash or a hex digit
// inside an escape yields no result on its own.
// Throughput: one input item per cycle while each item yields at most one
// byte and pop_i stays high. An item that yields several bytes (an unknown
// or malformed escape, or a flushed escape at the end) occupies the
// serializer, one byte per cycle while pop_i is high; the four-entry group
// queue absorbs this and full_o rises only once it is full.
// Reset: the decoder returns to normal mode, the held hex digit clears and
// the queue empties. When the receiver stalls, results wait in the queue
// and input is still taken until the queue fills.
`default_nettype none

module string_literal_unescaper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire sle_pkg::sle_in_t   in_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output sle_pkg::sle_out_t       out_o
);

  sle_pkg::sle_group_t grp, head;
  logic                grp_valid;
  logic                q_full, q_empty, q_pop;
  logic                accept;

  // Items are accepted whenever the queue has room; groups that hold no
  // bytes only advance the decoder state.
  assign accept = push_i && !q_full;
  assign full_o = q_full;

  sle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_i          (in_i),
    .group_o       (grp),
    .group_valid_o (grp_valid)
  );

  sle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_valid),
    .data_i  (grp),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  sle_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_o     (out_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

endmodule

`default_nettype wire

>>> design/sle_front.sv
// Front part of the string literal unescaper: accepts raw body bytes and
// decodes escapes into groups of result bytes. Depends on sle_pkg.
`default_nettype none

module sle_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire sle_pkg::sle_in_t  in_i,
  output sle_pkg::sle_group_t    group_o,
  output logic                   group_valid_o
);

  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeEscape = 2'd1;
  localparam logic [1:0] ModeHex1   = 2'd2;
  localparam logic [1:0] ModeHex2   = 2'd3;

  logic [1:0] mode_q, mode_d;
  logic [7:0] digit_q, digit_d;

  logic [7:0] b;
  logic       fin;
  logic       fresh_esc;
  logic [4:0] hex_b, hex_held;
  sle_pkg::sle_group_t grp;

  always_comb begin
    b         = in_i.data_byte;
    fin       = in_i.is_final;
    fresh_esc = (b == sle_pkg::CharBackslash) && !fin;
    hex_b     = sle_pkg::hex_decode(b);
    hex_held  = sle_pkg::hex_decode(digit_q);
    grp.bytes = '0;
    grp.count = '0;
    grp.fin   = fin;
    mode_d    = ModeNormal;
    digit_d   = digit_q;

    case (mode_q)
      ModeNormal: begin
        if (fresh_esc) begin
          mode_d = ModeEscape;
        end else begin
          grp.bytes[0] = b;
          grp.count    = sle_pkg::CntW'(1);
        end
      end
      ModeEscape: begin
        grp.count = sle_pkg::CntW'(1);
        case (b)
          sle_pkg::CharQuote:     grp.bytes[0] = sle_pkg::CharQuote;
          sle_pkg::CharBackslash: grp.bytes[0] = sle_pkg::CharBackslash;
          sle_pkg::CharLowerN:    grp.bytes[0] = sle_pkg::CharNewline;
          sle_pkg::CharLowerT:    grp.bytes[0] = sle_pkg::CharTab;
          sle_pkg::CharLowerR:    grp.bytes[0] = sle_pkg::CharReturn;
          sle_pkg::CharZero:      grp.bytes[0] = sle_pkg::CharNul;
          sle_pkg::CharLowerX: begin
            if (fin) begin
              grp.bytes[0] = sle_pkg::CharBackslash;
              grp.bytes[1] = sle_pkg::CharLowerX;
              grp.count    = sle_pkg::CntW'(2);
            end else begin
              grp.count = '0;
              mode_d    = ModeHex1;
            end
          end
          default: begin
            grp.bytes[0] = sle_pkg::CharBackslash;
            grp.bytes[1] = b;
            grp.count    = sle_pkg::CntW'(2);
          end
        endcase
      end
      ModeHex1: begin
        if (hex_b[4] && !fin) begin
          digit_d = b;
          mode_d  = ModeHex2;
        end else begin
          grp.bytes[0] = sle_pkg::CharBackslash;
          grp.bytes[1] = sle_pkg::CharLowerX;
          if (fresh_esc) begin
            grp.count = sle_pkg::CntW'(2);
            mode_d    = ModeEscape;
          end else begin
            grp.bytes[2] = b;
            grp.count    = sle_pkg::CntW'(3);
          end
        end
      end
      default: begin
        if (hex_held[4] && hex_b[4]) begin
          grp.bytes[0] = {hex_held[3:0], hex_b[3:0]};
          grp.count    = sle_pkg::CntW'(1);
        end else begin
          grp.bytes[0] = sle_pkg::CharBackslash;
          grp.bytes[1] = sle_pkg::CharLowerX;
          grp.bytes[2] = digit_q;
          if (fresh_esc) begin
            grp.count = sle_pkg::CntW'(3);
            mode_d    = ModeEscape;
          end else begin
            grp.bytes[3] = b;
            grp.count    = sle_pkg::CntW'(4);
          end
        end
      end
    endcase

    if (fin) begin
      mode_d = ModeNormal;
    end
  end

  assign group_o       = grp;
  assign group_valid_o = accept_i && (grp.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      digit_q <= 8'h00;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sle_queue.sv
// Short queue of decoded groups between the decoder and the serializer.
// Depends on sle_pkg.
`default_nettype none

module sle_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sle_pkg::sle_group_t data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output sle_pkg::sle_group_t      head_o,
  output logic                     empty_o
);

  sle_pkg::sle_group_t mem_q [sle_pkg::QueueDepth];

  logic [sle_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [sle_pkg::QCntW-1:0] cnt_q;
  logic                      do_push, do_pop;

  assign full_o  = (cnt_q == sle_pkg::QCntW'(sle_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + sle_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + sle_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + sle_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - sle_pkg::QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sle_back.sv
// Back part of the string literal unescaper: hands out the bytes of the
// oldest queued group one per result item. Depends on sle_pkg.
`default_nettype none

module sle_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sle_pkg::sle_group_t head_i,
  input  wire logic                q_empty_i,
  output logic                     q_pop_o,
  output sle_pkg::sle_out_t        out_o,
  output logic                     empty_o,
  input  wire logic                pop_i
);

  logic [sle_pkg::IdxW-1:0] idx_q;
  logic                     last;
  logic                     take;

  assign last    = ({1'b0, idx_q} == (head_i.count - sle_pkg::CntW'(1)));
  assign empty_o = q_empty_i;
  assign take    = pop_i && !q_empty_i;
  assign q_pop_o = take && last;

  assign out_o.out_byte      = head_i.bytes[idx_q];
  assign out_o.end_of_string = head_i.fin && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      if (last) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + sle_pkg::IdxW'(1);
      end
    end
  end

endmodule

`default_nettype wire
